// ===== rtl/wrtm_pkg.sv =====
// Shared types and constants of the wildcard rule table match unit.
package wrtm_pkg;

   localparam int FIDX_W  = 3;
   localparam int VAL_W   = 4;
   localparam int ENTRY_W = VAL_W + 1;
   localparam int ID_W    = 6;
   localparam int KIND_W  = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_INSERTED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MATCH    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NO_MATCH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FULL     = 2'd3;

   typedef struct packed {
      logic              func;
      logic [FIDX_W-1:0] factor_index;
      logic [VAL_W-1:0]  factor_value;
      logic              has_value;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   rule_id;
      logic              last_result;
   } rsp_type;

endpackage

// ===== rtl/wrtm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wrtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wrtm_row_match.sv =====
// Compares one stored rule row against the query pattern.
module wrtm_row_match
   import wrtm_pkg::*;
#(
   parameter int NUM_FACTORS = 8
) (
   input  logic [NUM_FACTORS-1:0][ENTRY_W-1:0] row,
   input  logic [NUM_FACTORS-1:0][VAL_W-1:0]   pat_val,
   input  logic [NUM_FACTORS-1:0]              pat_care,
   output logic                                hit
);

   logic [NUM_FACTORS-1:0] miss;

   always_comb begin
      for (int f = 0; f < NUM_FACTORS; f++) begin
         // a stored wildcard or an unqueried factor never misses
         miss[f] = pat_care[f] && row[f][VAL_W] && (row[f][VAL_W-1:0] != pat_val[f]);
      end
   end

   assign hit = ~|miss;

endmodule

// ===== rtl/wildcard_rule_table_match_unit.sv =====
// Top level of the wildcard rule table match unit: pattern build, insert and table scan.
// Timing: a non-closing beat only folds into the pattern and gives no result; a closing insert
//   answers from the insert state; a closing query's final result follows the last rule read.
// Throughput: one rule per cycle from the rule RAM; busy holds for the scan
//   or the insert. Results cannot be stalled.
// Reset: synchronous; clears rule count, pattern and control, not the rule RAM.
module wildcard_rule_table_match_unit
   import wrtm_pkg::*;
#(
   parameter int NUM_FACTORS = 8,
   parameter int MAX_RULES   = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(MAX_RULES);
   localparam int CNT_W  = $clog2(MAX_RULES + 1);
   localparam int ROW_W  = NUM_FACTORS * ENTRY_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_INSERT = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [CNT_W-1:0]                    scan_idx_ff, scan_idx_in;
   logic [NUM_FACTORS-1:0][VAL_W-1:0]   pat_val_ff, pat_val_in;
   logic [NUM_FACTORS-1:0]              pat_care_ff, pat_care_in;
   logic                                rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]                   rd_id_ff, rd_id_in;
   logic                                pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0]                   pend_id_ff, pend_id_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rsp_type                             rsp_ff, rsp_in;

   logic                                accept;
   logic                                issue;
   logic                                wr_en;
   logic [NUM_FACTORS-1:0][ENTRY_W-1:0] wr_row;
   logic [ROW_W-1:0]                    rd_row;
   logic                                hit;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   // issue one row read per cycle while unread stored rules remain
   assign issue  = (state_ff == S_SCAN) && (scan_idx_ff < cnt_ff);
   assign wr_en  = (state_ff == S_INSERT) && (cnt_ff != CNT_W'(MAX_RULES));

   always_comb begin
      for (int f = 0; f < NUM_FACTORS; f++) begin
         wr_row[f] = pat_care_ff[f] ? {1'b1, pat_val_ff[f]} : '0;
      end
   end

   wrtm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_RULES)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (wr_row),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_row)
   );

   wrtm_row_match #(
      .NUM_FACTORS (NUM_FACTORS)
   ) u_row_match (
      .row      (rd_row),
      .pat_val  (pat_val_ff),
      .pat_care (pat_care_ff),
      .hit      (hit)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scan_idx_in  = scan_idx_ff;
      pat_val_in   = pat_val_ff;
      pat_care_in  = pat_care_ff;
      rd_vld_in    = issue;
      rd_id_in     = scan_idx_ff[ADDR_W-1:0];
      pend_vld_in  = pend_vld_ff;
      pend_id_in   = pend_id_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // fold the beat into the pattern; the closing beat counts too
               for (int f = 0; f < NUM_FACTORS; f++) begin
                  if (req_data.has_value && (32'(req_data.factor_index) == f)) begin
                     pat_care_in[f] = 1'b1;
                     pat_val_in[f]  = req_data.factor_value;
                  end
               end
               if (req_data.last) begin
                  scan_idx_in = '0;
                  pend_vld_in = 1'b0;
                  state_in    = (req_data.func == FUNC_QUERY) ? S_SCAN : S_INSERT;
               end
            end
         end
         S_INSERT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.last_result = 1'b1;
            if (cnt_ff == CNT_W'(MAX_RULES)) begin
               rsp_in.kind    = KIND_FULL;
               rsp_in.rule_id = '0;
            end else begin
               rsp_in.kind    = KIND_INSERTED;
               rsp_in.rule_id = ID_W'(cnt_ff);
               cnt_in         = cnt_ff + 1'b1;
            end
            pat_care_in = '0;
            pat_val_in  = '0;
            state_in    = S_IDLE;
         end
         S_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (rd_vld_ff && hit) begin
               // release the held match, now known not to be the final one
               if (pend_vld_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.kind        = KIND_MATCH;
                  rsp_in.rule_id     = ID_W'(pend_id_ff);
                  rsp_in.last_result = 1'b0;
               end
               pend_vld_in = 1'b1;
               pend_id_in  = rd_id_ff;
            end
            if (!issue && !rd_vld_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.last_result = 1'b1;
               if (pend_vld_ff) begin
                  rsp_in.kind    = KIND_MATCH;
                  rsp_in.rule_id = ID_W'(pend_id_ff);
               end else begin
                  rsp_in.kind    = KIND_NO_MATCH;
                  rsp_in.rule_id = '0;
               end
               pend_vld_in = 1'b0;
               pat_care_in = '0;
               pat_val_in  = '0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         scan_idx_ff  <= '0;
         pat_val_ff   <= '0;
         pat_care_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_idx_ff  <= scan_idx_in;
         pat_val_ff   <= pat_val_in;
         pat_care_ff  <= pat_care_in;
         rd_vld_ff    <= rd_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      rd_id_ff   <= rd_id_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // rule count never passes the table size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RULES))
      else $error("rule count exceeds table size");

   // a read in flight only exists during a scan
   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_SCAN))
      else $error("row read outside scan");

   // the final beat of an item coincides with return to idle
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_result) |-> (state_ff == S_IDLE))
      else $error("final result while still busy");

   // a non-final beat only comes out of an ongoing scan
   a_mid_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_result) |-> (state_ff == S_SCAN))
      else $error("non-final result outside scan");

   // a closing beat always makes the unit busy
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last) |=> busy)
      else $error("closing beat did not start work");

endmodule
